@@ rtl/core/acss_pkg.sv @@
// Package for the adaptive cruise speed step unit: field widths, register
// indexes with their reset values, and the mode codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acss_pkg;

	localparam int SpeedW  = 16;
	localparam int PosW    = 24;
	localparam int HeadW   = 12;
	localparam int GainW   = 10;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 16;

	localparam logic [CfgIdxW-1:0] CFG_CRUISE_SET_SPEED = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_MIN_ACTIVE_SPEED = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_MIN_GAP          = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_HEADWAY_TIME     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_WIDENED_GAIN     = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_BLEND_GAIN       = 3'd5;

	localparam logic [SpeedW-1:0] RST_CRUISE_SET_SPEED = 16'd0;
	localparam logic [SpeedW-1:0] RST_MIN_ACTIVE_SPEED = 16'd1280;
	localparam logic [SpeedW-1:0] RST_MIN_GAP          = 16'd1280;
	localparam logic [HeadW-1:0]  RST_HEADWAY_TIME     = 12'd512;
	localparam logic [GainW-1:0]  RST_WIDENED_GAIN     = 10'd435;
	localparam logic [SpeedW-1:0] RST_BLEND_GAIN       = 16'd26214;

	localparam logic [GainW-1:0]  UNITY_GAIN = 10'd256;

	typedef enum logic [1:0] {
		MODE_OFF           = 2'd0,
		MODE_FOLLOW        = 2'd1,
		MODE_CRUISE_LEADER = 2'd2,
		MODE_CRUISE        = 2'd3
	} mode_t;

endpackage : acss_pkg

`default_nettype wire

@@ rtl/core/acss_if.sv @@
// Channel interfaces of the adaptive cruise speed step unit: measurement
// channel in, command channel out. Depends on acss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface acss_meas_if;
	import acss_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [SpeedW-1:0]        current_speed;
	logic                     leader_valid;
	logic signed [PosW-1:0]   leader_dx;
	logic signed [PosW-1:0]   leader_dy;
	logic [SpeedW-1:0]        leader_speed;

	modport source (output valid, current_speed, leader_valid, leader_dx, leader_dy,
		leader_speed, input ready);
	modport sink (input valid, current_speed, leader_valid, leader_dx, leader_dy,
		leader_speed, output ready);
endinterface : acss_meas_if

interface acss_cmd_if;
	import acss_pkg::*;

	logic              valid;
	logic              ready;
	logic [SpeedW-1:0] speed_command;
	logic [1:0]        mode;
	logic              deactivate;

	modport source (output valid, speed_command, mode, deactivate, input ready);
	modport sink (input valid, speed_command, mode, deactivate, output ready);
endinterface : acss_cmd_if

`default_nettype wire

@@ rtl/core/adaptive_cruise_speed_step_unit.sv @@
// Adaptive cruise speed step unit: sequencer around one shared multiplier
// and one shared 48-bit subtractor. Depends on acss_pkg and acss_if.
//
// Usage:
// - meas channel (sink) takes one control tick: host speed and, when
//   leader_valid is set, leader offset and leader speed. cmd channel
//   (source) returns one speed command, mode and deactivate per tick.
// - The unit handles one transaction at a time; meas.ready is high only
//   while it is idle. Registers must be written through
//   wr_en/wr_index/wr_data only while idle; the unit itself does not
//   enforce this. Indexes beyond the list are ignored.
// - A low-speed tick is answered straight from idle. With no leader only
//   the blend steps run. With a leader the 24-step square root on the
//   shared subtractor runs first and, when following, the 16-step
//   restoring divide on it, skipped when the quotient saturates.
//   meas.ready rises the cycle after the command is taken.
// - A stalled cmd.ready holds the result in its output registers; no new
//   measurement is taken until it is delivered.
// - Reset restores register defaults, clears the widened-gain flag and
//   returns to idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_cruise_speed_step_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	acss_meas_if.sink                          meas,
	acss_cmd_if.source                         cmd,
	input  wire logic                          wr_en,
	input  wire logic [acss_pkg::CfgIdxW-1:0]  wr_index,
	input  wire logic [acss_pkg::CfgW-1:0]     wr_data
);
	import acss_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SQSUM,
		ST_SQRT,
		ST_SAFE_MUL,
		ST_SAFE_ADD,
		ST_GAIN_MUL,
		ST_CMP,
		ST_NUM_MUL,
		ST_NUM_SAT,
		ST_DIV,
		ST_CAP,
		ST_BLEND_DIFF,
		ST_BLEND_MUL,
		ST_BLEND_OUT
	} state_t;

	// configuration
	logic [SpeedW-1:0] set_speed_q;
	logic [SpeedW-1:0] min_active_q;
	logic [SpeedW-1:0] min_gap_q;
	logic [HeadW-1:0]  headway_q;
	logic [GainW-1:0]  wgain_q;
	logic [SpeedW-1:0] blend_q;

	// sequencer and datapath
	state_t            state_q;
	logic              out_valid_q;
	logic [4:0]        k_q;
	logic [SpeedW-1:0] cur_q;
	logic [PosW-1:0]   ax_q;
	logic [PosW-1:0]   ay_q;
	logic [SpeedW-1:0] lspeed_q;
	logic [47:0]       rad_q;
	logic [47:0]       root_q;
	logic [20:0]       safe_q;
	logic [47:0]       prod_q;
	logic [39:0]       rem_q;
	logic [SpeedW-1:0] quo_q;
	logic [SpeedW-1:0] desired_q;
	logic [SpeedW-1:0] diff_q;
	logic              down_q;
	logic              widened_q;
	logic [SpeedW-1:0] cmd_q;
	mode_t             mode_q;
	logic              deact_q;

	logic [PosW-1:0]   mag_x;
	logic [PosW-1:0]   mag_y;
	logic [23:0]       mul_a;
	logic [23:0]       mul_b;
	logic [47:0]       sub_a;
	logic [47:0]       sub_b;
	logic [48:0]       sub_r;
	logic              borrow;
	logic [47:0]       sqrt_bit;
	logic [31:0]       rnd;
	logic [SpeedW-1:0] step;
	logic              in_fire;

	assign meas.ready        = (state_q == ST_IDLE) && !out_valid_q;
	assign in_fire           = meas.valid && meas.ready;
	assign cmd.valid         = out_valid_q;
	assign cmd.speed_command = cmd_q;
	assign cmd.mode          = mode_q;
	assign cmd.deactivate    = deact_q;

	assign mag_x    = meas.leader_dx[PosW-1] ? (PosW'(0) - PosW'(meas.leader_dx))
		: PosW'(meas.leader_dx);
	assign mag_y    = meas.leader_dy[PosW-1] ? (PosW'(0) - PosW'(meas.leader_dy))
		: PosW'(meas.leader_dy);
	assign sqrt_bit = 48'd1 << {k_q, 1'b0};

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			ST_SQX: begin
				mul_a = ax_q;
				mul_b = ax_q;
			end
			ST_SQY: begin
				mul_a = ay_q;
				mul_b = ay_q;
			end
			ST_SAFE_MUL: begin
				mul_a = 24'(cur_q);
				mul_b = 24'(headway_q);
			end
			ST_GAIN_MUL: begin
				mul_a = 24'(safe_q);
				mul_b = 24'(widened_q ? wgain_q : UNITY_GAIN);
			end
			ST_NUM_MUL: begin
				mul_a = 24'(lspeed_q);
				mul_b = root_q[23:0];
			end
			ST_BLEND_MUL: begin
				mul_a = 24'(diff_q);
				mul_b = 24'(blend_q);
			end
			default: begin
				mul_a = 24'd0;
				mul_b = 24'd0;
			end
		endcase
	end

	// shared subtractor operands
	always_comb begin
		unique case (state_q)
			ST_SQRT: begin
				sub_a = rad_q;
				sub_b = root_q | sqrt_bit;
			end
			ST_CMP: begin
				sub_a = 48'({root_q[23:0], 8'h00});
				sub_b = prod_q;
			end
			ST_NUM_SAT: begin
				sub_a = 48'(prod_q[39:0]);
				sub_b = 48'({safe_q, 16'h0000});
			end
			ST_DIV: begin
				sub_a = 48'(rem_q);
				sub_b = 48'(safe_q) << k_q;
			end
			ST_BLEND_DIFF: begin
				sub_a = 48'(desired_q);
				sub_b = 48'(cur_q);
			end
			default: begin
				sub_a = 48'd0;
				sub_b = 48'd0;
			end
		endcase
	end

	assign sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = sub_r[48];
	assign rnd    = prod_q[31:0] + 32'h0000_8000;
	assign step   = rnd[31:16];

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_speed_q  <= RST_CRUISE_SET_SPEED;
			min_active_q <= RST_MIN_ACTIVE_SPEED;
			min_gap_q    <= RST_MIN_GAP;
			headway_q    <= RST_HEADWAY_TIME;
			wgain_q      <= RST_WIDENED_GAIN;
			blend_q      <= RST_BLEND_GAIN;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_CRUISE_SET_SPEED: set_speed_q  <= wr_data;
				CFG_MIN_ACTIVE_SPEED: min_active_q <= wr_data;
				CFG_MIN_GAP:          min_gap_q    <= wr_data;
				CFG_HEADWAY_TIME:     headway_q    <= wr_data[HeadW-1:0];
				CFG_WIDENED_GAIN:     wgain_q      <= wr_data[GainW-1:0];
				CFG_BLEND_GAIN:       blend_q      <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			widened_q   <= 1'b0;
			k_q         <= '0;
			cur_q       <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			lspeed_q    <= '0;
			rad_q       <= '0;
			root_q      <= '0;
			safe_q      <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			desired_q   <= '0;
			diff_q      <= '0;
			down_q      <= 1'b0;
			cmd_q       <= '0;
			mode_q      <= MODE_OFF;
			deact_q     <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cur_q     <= meas.current_speed;
						ax_q      <= mag_x;
						ay_q      <= mag_y;
						lspeed_q  <= meas.leader_speed;
						desired_q <= set_speed_q;
						deact_q   <= (meas.current_speed < min_active_q);
						priority if (meas.current_speed < min_active_q) begin
							cmd_q       <= meas.current_speed;
							mode_q      <= MODE_OFF;
							out_valid_q <= 1'b1;
						end else if (!meas.leader_valid) begin
							mode_q  <= MODE_CRUISE;
							state_q <= ST_BLEND_DIFF;
						end else begin
							state_q <= ST_SQX;
						end
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: begin
					rad_q   <= prod_q;
					state_q <= ST_SQSUM;
				end
				ST_SQSUM: begin
					rad_q   <= rad_q + prod_q;
					root_q  <= '0;
					k_q     <= 5'd23;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (!borrow) begin
						rad_q  <= sub_r[47:0];
						root_q <= (root_q >> 1) + sqrt_bit;
					end else begin
						root_q <= root_q >> 1;
					end
					k_q <= k_q - 5'd1;
					if (k_q == 5'd0) begin
						state_q <= ST_SAFE_MUL;
					end
				end
				ST_SAFE_MUL: state_q <= ST_SAFE_ADD;
				ST_SAFE_ADD: begin
					safe_q  <= 21'(min_gap_q) + 21'(prod_q[27:8]);
					state_q <= ST_GAIN_MUL;
				end
				ST_GAIN_MUL: state_q <= ST_CMP;
				ST_CMP: begin
					if (borrow) begin
						widened_q <= 1'b1;
						mode_q    <= MODE_FOLLOW;
						state_q   <= ST_NUM_MUL;
					end else begin
						mode_q    <= MODE_CRUISE_LEADER;
						state_q   <= ST_BLEND_DIFF;
					end
				end
				ST_NUM_MUL: state_q <= ST_NUM_SAT;
				ST_NUM_SAT: begin
					rem_q <= prod_q[39:0];
					quo_q <= {SpeedW{!borrow}};
					k_q   <= 5'd15;
					if (!borrow) begin
						state_q <= ST_CAP;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!borrow) begin
						rem_q <= sub_r[39:0];
					end
					quo_q <= {quo_q[SpeedW-2:0], !borrow};
					k_q   <= k_q - 5'd1;
					if (k_q == 5'd0) begin
						state_q <= ST_CAP;
					end
				end
				ST_CAP: begin
					desired_q <= (quo_q > set_speed_q) ? set_speed_q : quo_q;
					state_q   <= ST_BLEND_DIFF;
				end
				ST_BLEND_DIFF: begin
					down_q  <= borrow;
					diff_q  <= borrow ? (SpeedW'(0) - sub_r[SpeedW-1:0]) : sub_r[SpeedW-1:0];
					state_q <= ST_BLEND_MUL;
				end
				ST_BLEND_MUL: state_q <= ST_BLEND_OUT;
				ST_BLEND_OUT: begin
					cmd_q       <= down_q ? (cur_q - step) : (cur_q + step);
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : adaptive_cruise_speed_step_unit

`default_nettype wire

@@ rtl/core/acss_checker.sv @@
// Port-level checks for the adaptive cruise speed step unit, bound to the
// top level. Depends on acss_pkg and adaptive_cruise_speed_step_unit.
`timescale 1ns / 1ps
`default_nettype none

module acss_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [acss_pkg::SpeedW-1:0] speed_command,
	input wire logic [1:0]                  mode,
	input wire logic                        deactivate
);
	import acss_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(speed_command)
			&& $stable(mode) && $stable(deactivate))
		else $error("stalled command changed");

	a_deact: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (deactivate == (mode == MODE_OFF)))
		else $error("deactivate disagrees with mode");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second transaction while busy");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("ready while a command is pending");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("command repeated");

endmodule : acss_checker

bind adaptive_cruise_speed_step_unit acss_checker u_acss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (meas.valid),
	.in_ready      (meas.ready),
	.out_valid     (cmd.valid),
	.out_ready     (cmd.ready),
	.speed_command (cmd.speed_command),
	.mode          (cmd.mode),
	.deactivate    (cmd.deactivate)
);

`default_nettype wire
